// ===== rtl/fixed_frame_receiver_sum_check_unit_macros.svh =====
// assertion macros for the fixed frame receiver with sum check
`ifndef FIXED_FRAME_RECEIVER_SUM_CHECK_UNIT_MACROS_SVH
`define FIXED_FRAME_RECEIVER_SUM_CHECK_UNIT_MACROS_SVH

// same-cycle implication
`define FFSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FFSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ffsc_pkg.sv =====
// shared types and constants for the fixed frame receiver
package ffsc_pkg;

	typedef logic [7:0] byte_t;
	typedef logic [2:0] pos_t;

	localparam byte_t SYNC_RESET       = 8'hAA;
	localparam pos_t  POS_IDLE         = 3'd0;
	localparam pos_t  POS_LAST_PAYLOAD = 3'd5;
	localparam pos_t  POS_CHECK        = 3'd6;
	localparam pos_t  POS_TAIL         = 3'd7;

endpackage

// ===== rtl/ffsc_if.sv =====
// channel interfaces: received bytes, frame results, configuration writes
interface ffsc_rx_if;
	import ffsc_pkg::*;
	logic  valid;
	logic  ready;
	byte_t rx_byte;
	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

interface ffsc_frame_if;
	import ffsc_pkg::*;
	logic  valid;
	logic  ready;
	byte_t payload_a;
	byte_t payload_b;
	byte_t payload_c;
	byte_t payload_d;
	byte_t payload_e;
	byte_t check_value;
	byte_t tail_value;
	logic  sum_ok;
	modport source(
		output valid, output payload_a, output payload_b, output payload_c,
		output payload_d, output payload_e, output check_value, output tail_value,
		output sum_ok, input ready
	);
	modport sink(
		input valid, input payload_a, input payload_b, input payload_c,
		input payload_d, input payload_e, input check_value, input tail_value,
		input sum_ok, output ready
	);
endinterface

interface ffsc_cfg_if;
	import ffsc_pkg::*;
	logic  valid;
	logic  ready;
	byte_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/fixed_frame_receiver_sum_check_unit.sv =====
// top level: sync-started eight-byte frame receiver with additive sum check
//
// Takes one received byte per cycle. While idle a byte equal to the sync
// register opens a frame; every following byte is stored until the eighth,
// which closes the frame and produces one result beat carrying the five
// payload bytes, the check byte, the tail byte and the sum-ok flag. The
// closing byte is held in the input register; then the position counter,
// running sum and frame store update together with the result register.
// Sustained rate is one byte per cycle, set by the position counter and
// the 8-bit running sum updating once per byte. Input back-pressure occurs
// only when a closing byte finds the previous result still waiting to be
// taken. Sync register writes are accepted every cycle and apply from the
// next frame opening.
module fixed_frame_receiver_sum_check_unit (
	input logic         clk,
	input logic         arst_n,
	ffsc_rx_if.sink     rx,
	ffsc_frame_if.source frame,
	ffsc_cfg_if.sink    cfg
);
	import ffsc_pkg::*;

	logic  valid_s1;
	byte_t byte_s1;
	byte_t sync_q;
	pos_t  pos_q;
	byte_t sum_q;
	byte_t store_q [1:6];

	logic  res_valid_q;
	byte_t res_pay_q [1:5];
	byte_t res_check_q;
	byte_t res_tail_q;
	logic  res_ok_q;

	logic  emit;
	logic  advance_s1;
	logic  take_rx;

	assign emit       = valid_s1 && (pos_q == POS_TAIL);
	assign advance_s1 = valid_s1 && (!emit || !res_valid_q || frame.ready);
	assign rx.ready   = !valid_s1 || advance_s1;
	assign take_rx    = rx.valid && rx.ready;
	assign cfg.ready  = 1'b1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_rx) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// sync register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= SYNC_RESET;
		end else if (cfg.valid) begin
			sync_q <= cfg.data;
		end
	end

	// frame tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_IDLE;
			sum_q <= '0;
		end else if (advance_s1) begin
			if (pos_q == POS_IDLE) begin
				if (byte_s1 == sync_q) begin
					pos_q <= 3'd1;
					sum_q <= '0;
				end
			end else if (pos_q == POS_TAIL) begin
				pos_q <= POS_IDLE;
			end else begin
				pos_q <= 3'(pos_q + 3'd1);
				if (pos_q <= POS_LAST_PAYLOAD) begin
					sum_q <= 8'(sum_q + byte_s1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			for (int i = 1; i <= 6; i++) begin
				if (pos_q == 3'(i)) begin
					store_q[i] <= byte_s1;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance_s1 && emit) begin
			res_valid_q <= 1'b1;
		end else if (frame.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && emit) begin
			for (int i = 1; i <= 5; i++) begin
				res_pay_q[i] <= store_q[i];
			end
			res_check_q <= store_q[POS_CHECK];
			res_tail_q  <= byte_s1;
			res_ok_q    <= (sum_q == store_q[POS_CHECK]);
		end
	end

	assign frame.valid       = res_valid_q;
	assign frame.payload_a   = res_pay_q[1];
	assign frame.payload_b   = res_pay_q[2];
	assign frame.payload_c   = res_pay_q[3];
	assign frame.payload_d   = res_pay_q[4];
	assign frame.payload_e   = res_pay_q[5];
	assign frame.check_value = res_check_q;
	assign frame.tail_value  = res_tail_q;
	assign frame.sum_ok      = res_ok_q;

endmodule

// ===== rtl/ffsc_checker.sv =====
// port-level checker for the frame receiver, bound to the top level
`include "fixed_frame_receiver_sum_check_unit_macros.svh"

module ffsc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                rx_ready,
	input logic                res_valid,
	input logic                res_ready,
	input ffsc_pkg::byte_t     payload_a,
	input ffsc_pkg::byte_t     payload_b,
	input ffsc_pkg::byte_t     payload_c,
	input ffsc_pkg::byte_t     payload_d,
	input ffsc_pkg::byte_t     payload_e,
	input ffsc_pkg::byte_t     check_value,
	input ffsc_pkg::byte_t     tail_value,
	input logic                sum_ok
);
	import ffsc_pkg::*;

	logic [56:0] res_bits;
	byte_t       pay_sum;

	assign res_bits = {payload_a, payload_b, payload_c, payload_d, payload_e,
		check_value, tail_value, sum_ok};
	assign pay_sum  = 8'(payload_a + payload_b + payload_c + payload_d + payload_e);

	`FFSC_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid, "result beat dropped while stalled")
	`FFSC_ASSERT_NEXT(a_res_stable, clk, arst_n, res_valid && !res_ready, $stable(res_bits), "result beat changed while stalled")
	`FFSC_ASSERT_IMP(a_sum_flag, clk, arst_n, res_valid, sum_ok == (pay_sum == check_value), "sum flag disagrees with payload")
	`FFSC_ASSERT_IMP(a_rx_free, clk, arst_n, !res_valid, rx_ready, "byte input stalled with result slot empty")

endmodule

bind fixed_frame_receiver_sum_check_unit ffsc_checker u_ffsc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rx_ready    (rx.ready),
	.res_valid   (frame.valid),
	.res_ready   (frame.ready),
	.payload_a   (frame.payload_a),
	.payload_b   (frame.payload_b),
	.payload_c   (frame.payload_c),
	.payload_d   (frame.payload_d),
	.payload_e   (frame.payload_e),
	.check_value (frame.check_value),
	.tail_value  (frame.tail_value),
	.sum_ok      (frame.sum_ok)
);

// ===== tb/testbench.sv =====
// self-checking testbench for the fixed frame receiver with additive sum check
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import ffsc_pkg::*;

	localparam int RESULT_LATENCY = 2;
	localparam int PHASES = 6;
	localparam int PHASE_BYTES = 64;

	typedef struct packed {
		byte_t payload_a;
		byte_t payload_b;
		byte_t payload_c;
		byte_t payload_d;
		byte_t payload_e;
		byte_t check_value;
		byte_t tail_value;
		logic  sum_ok;
	} frame_beat_t;

	typedef struct {
		byte_t       data;
		bit          typed;
		frame_beat_t want;
	} stim_row_t;

	localparam frame_beat_t NO_BEAT = '0;

	logic clk = 1'b0;
	logic arst_n;

	ffsc_rx_if    rx_ch();
	ffsc_frame_if frame_ch();
	ffsc_cfg_if   cfg_ch();

	fixed_frame_receiver_sum_check_unit dut (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx_ch),
		.frame (frame_ch),
		.cfg   (cfg_ch)
	);

	stim_row_t stim_table [29] = '{
		'{8'h00, 1'b0, NO_BEAT},
		'{8'hFF, 1'b0, NO_BEAT},
		'{8'hAA, 1'b0, NO_BEAT},
		'{8'h01, 1'b0, NO_BEAT},
		'{8'h02, 1'b0, NO_BEAT},
		'{8'h03, 1'b0, NO_BEAT},
		'{8'h04, 1'b0, NO_BEAT},
		'{8'h05, 1'b0, NO_BEAT},
		'{8'h0F, 1'b0, NO_BEAT},
		'{8'h00, 1'b1, '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h0F, 8'h00, 1'b1}},
		'{8'hAA, 1'b0, NO_BEAT},
		'{8'hFF, 1'b0, NO_BEAT},
		'{8'hFF, 1'b0, NO_BEAT},
		'{8'hFF, 1'b0, NO_BEAT},
		'{8'hFF, 1'b0, NO_BEAT},
		'{8'hFF, 1'b0, NO_BEAT},
		'{8'hFB, 1'b0, NO_BEAT},
		'{8'hFF, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFB, 8'hFF, 1'b1}},
		'{8'hAA, 1'b0, NO_BEAT},
		'{8'h00, 1'b0, NO_BEAT},
		'{8'h00, 1'b0, NO_BEAT},
		'{8'hAA, 1'b0, NO_BEAT},
		'{8'h00, 1'b0, NO_BEAT},
		'{8'h00, 1'b0, NO_BEAT},
		'{8'h00, 1'b0, NO_BEAT},
		'{8'hAA, 1'b1, '{8'h00, 8'h00, 8'hAA, 8'h00, 8'h00, 8'h00, 8'hAA, 1'b0}},
		'{8'hAA, 1'b0, NO_BEAT},
		'{8'h11, 1'b0, NO_BEAT},
		'{8'h22, 1'b0, NO_BEAT}
	};

	byte_t       sync_cur;
	pos_t        rx_pos;
	byte_t       rx_sum;
	byte_t       frame_bytes [1:6];
	frame_beat_t frames_due [$];

	int errors = 0;
	int bytes_offered = 0;
	int bytes_taken = 0;
	int frames_seen = 0;
	int bad_sums = 0;
	int sync_writes = 0;
	int hold_len = 0;
	bit tx_no_idle = 1'b0;
	bit rx_no_idle = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic bit frame_step(input byte_t b, output frame_beat_t res);
		bit closes;
		closes = 1'b0;
		res = NO_BEAT;
		if (rx_pos == POS_IDLE) begin
			if (b == sync_cur) begin
				rx_sum = 8'h00;
				rx_pos = 3'd1;
				bytes_taken++;
			end
		end else if (rx_pos != POS_TAIL) begin
			frame_bytes[rx_pos] = b;
			if (rx_pos <= POS_LAST_PAYLOAD)
				rx_sum = rx_sum + b;
			rx_pos = rx_pos + 3'd1;
			bytes_taken++;
		end else begin
			res = '{frame_bytes[1], frame_bytes[2], frame_bytes[3], frame_bytes[4],
				frame_bytes[5], frame_bytes[POS_CHECK], b, rx_sum == frame_bytes[POS_CHECK]};
			rx_pos = POS_IDLE;
			closes = 1'b1;
			bytes_taken++;
		end
		return closes;
	endfunction

	task automatic send_byte(input byte_t b, input bit typed, input frame_beat_t want);
		int gap;
		bit closes;
		frame_beat_t got;
		gap = tx_no_idle ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
		bytes_offered++;
		closes = frame_step(b, got);
		if (typed && (!closes || got !== want)) begin
			errors++;
			$display("%0t: table byte %h expected beat %h, predictor gives %h",
				$time, b, want, got);
		end
		if (closes)
			frames_due.push_back(typed ? want : got);
		@(negedge clk);
	endtask

	task automatic send_frame();
		byte_t payload [5];
		byte_t sum;
		sum = 8'h00;
		send_byte(sync_cur, 1'b0, NO_BEAT);
		foreach (payload[i]) begin
			payload[i] = ($urandom_range(0, 9) == 0) ? sync_cur : byte_t'($urandom);
			sum = sum + payload[i];
			send_byte(payload[i], 1'b0, NO_BEAT);
		end
		send_byte(($urandom_range(0, 3) != 0) ? sum : byte_t'($urandom), 1'b0, NO_BEAT);
		send_byte(byte_t'($urandom), 1'b0, NO_BEAT);
	endtask

	task automatic settle();
		rx_ch.valid <= 1'b0;
		@(negedge clk);
		while (frames_due.size() != 0) @(negedge clk);
		repeat (RESULT_LATENCY + 2) @(negedge clk);
	endtask

	task automatic write_sync(input byte_t v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= v;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		sync_cur = v;
		sync_writes++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %h actual %h", $time, what, want, got);
		end
	endtask

	initial begin
		frame_beat_t want;
		frame_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			int stall;
			stall = rx_no_idle ? 0 : $urandom_range(0, 16);
			if (hold_len > 0) begin
				stall = hold_len;
				hold_len = 0;
			end
			@(negedge clk);
			if (stall > 0) begin
				frame_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			frame_ch.ready <= 1'b1;
			@(posedge clk);
			while (!frame_ch.valid) @(posedge clk);
			frames_seen++;
			if (!frame_ch.sum_ok)
				bad_sums++;
			if (frames_due.size() == 0) begin
				errors++;
				$display("%0t: result beat with nothing expected, actual %h %h %h %h %h %h %h %b",
					$time, frame_ch.payload_a, frame_ch.payload_b, frame_ch.payload_c,
					frame_ch.payload_d, frame_ch.payload_e, frame_ch.check_value,
					frame_ch.tail_value, frame_ch.sum_ok);
			end else begin
				want = frames_due.pop_front();
				check_field("payload_a", want.payload_a, frame_ch.payload_a);
				check_field("payload_b", want.payload_b, frame_ch.payload_b);
				check_field("payload_c", want.payload_c, frame_ch.payload_c);
				check_field("payload_d", want.payload_d, frame_ch.payload_d);
				check_field("payload_e", want.payload_e, frame_ch.payload_e);
				check_field("check_value", want.check_value, frame_ch.check_value);
				check_field("tail_value", want.tail_value, frame_ch.tail_value);
				check_field("sum_ok", want.sum_ok, frame_ch.sum_ok);
			end
		end
	end

	initial begin
		int start;
		int pick;
		byte_t next_sync;
		arst_n = 1'b0;
		rx_ch.valid <= 1'b0;
		rx_ch.rx_byte <= 8'h00;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data <= 8'h00;
		sync_cur = SYNC_RESET;
		rx_pos = POS_IDLE;
		rx_sum = 8'h00;
		foreach (frame_bytes[i])
			frame_bytes[i] = 8'h00;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset sync value, then a frame left open across the first write
		foreach (stim_table[i])
			send_byte(stim_table[i].data, stim_table[i].typed, stim_table[i].want);

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			case (ph)
				0: next_sync = 8'h00;
				1: next_sync = 8'hFF;
				3: next_sync = SYNC_RESET;
				default: next_sync = byte_t'($urandom);
			endcase
			write_sync(next_sync);
			tx_no_idle = (ph == 1) || (ph == 3);
			rx_no_idle = (ph == 1);
			if (ph == 3)
				hold_len = 250;
			start = bytes_taken;
			while (bytes_taken - start < PHASE_BYTES) begin
				pick = $urandom_range(0, 9);
				if (pick < 7) begin
					send_frame();
				end else if (pick == 7) begin
					send_byte(sync_cur, 1'b0, NO_BEAT);
					repeat ($urandom_range(1, 6))
						send_byte(byte_t'($urandom), 1'b0, NO_BEAT);
				end else begin
					repeat ($urandom_range(1, 4))
						send_byte(byte_t'($urandom), 1'b0, NO_BEAT);
				end
			end
			// leave a frame open so the next write lands mid-frame
			if (ph % 2 == 0 && rx_pos == POS_IDLE) begin
				send_byte(sync_cur, 1'b0, NO_BEAT);
				send_byte(byte_t'($urandom), 1'b0, NO_BEAT);
				send_byte(byte_t'($urandom), 1'b0, NO_BEAT);
			end
		end
		tx_no_idle = 1'b0;
		rx_no_idle = 1'b0;
		settle();

		$display("run offered %0d bytes, %0d taken into frames, %0d result beats (%0d bad sums)",
			bytes_offered, bytes_taken, frames_seen, bad_sums);
		$display("sync register written %0d times, with output hold-off and mid-frame writes",
			sync_writes);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#10ms;
		$display("timeout with %0d result beats outstanding", frames_due.size());
		$display("FAILURE");
		$finish;
	end

endmodule

// ===== fixed_frame_receiver_sum_check_unit.f =====
+incdir+rtl
rtl/ffsc_pkg.sv
rtl/ffsc_if.sv
rtl/fixed_frame_receiver_sum_check_unit.sv
rtl/ffsc_checker.sv
tb/testbench.sv
